// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the event table RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence in the same cycle
`define HET_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// consequence in the next cycle
`define HET_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/het_pkg.sv =====
// Shared types and codes for the hashed event table.
// No dependencies.
package het_pkg;

	typedef enum logic [3:0] {
		CMD_FIND     = 4'd0,
		CMD_FREE     = 4'd1,
		CMD_WRITE    = 4'd2,
		CMD_CLEAR    = 4'd3,
		CMD_CLR_ALL  = 4'd4,
		CMD_COUNT    = 4'd5,
		CMD_RD_HASH  = 4'd6,
		CMD_RD_VAR   = 4'd7,
		CMD_WR_VAR   = 4'd8
	} cmd_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_MISS  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic       CFG_SLOTS = 1'b0;
	localparam logic       CFG_VARS  = 1'b1;

	localparam logic [15:0] EMPTY_ID = 16'hFFFF;

	typedef struct packed {
		logic        we;
		logic        clr_all;
		logic [7:0]  addr;
		logic [7:0]  hash;
		logic [15:0] node;
		logic [15:0] evt;
	} het_wr_t;

endpackage

// ===== hdl/het_hash.sv =====
// Hash of a node/event pair: folded bytes, 7*e+n, reduced by the modulus.
// Depends on nothing beyond its parameter.
module het_hash #(
	parameter int HASH_MODULUS = 128
) (
	input  logic [15:0] node,
	input  logic [15:0] evt,
	output logic [7:0]  hash
);
	logic [7:0] fn, fe, h8;
	logic [8:0] hm;

	always_comb begin
		fn = node[15:8] ^ node[7:0];
		fe = evt[15:8] ^ evt[7:0];
		h8 = 8'((11'(fe) * 11'd7) + 11'(fn));
		hm = 9'(9'(h8) % HASH_MODULUS);
		hash = (hm == 9'd0) ? 8'hFF : hm[7:0];
	end
endmodule

// ===== hdl/het_store.sv =====
// Slot store: hash memory with per-slot valid bits and node/event pair memory.
// Depends on het_pkg for the write request type.
module het_store #(
	parameter int MAX_SLOTS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  het_pkg::het_wr_t wr,
	input  logic            rd_en,
	input  logic [7:0]      rd_addr,
	output logic [7:0]      hash_rd,
	output logic [15:0]     node_rd,
	output logic [15:0]     evt_rd
);
	localparam int AW = $clog2(MAX_SLOTS);

	logic [7:0]  hash_mem [MAX_SLOTS];
	logic [31:0] pair_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] valid_q;
	logic [7:0]  hraw_q;
	logic        vld_q;
	logic [31:0] pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.clr_all) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			hash_mem[wr.addr[AW-1:0]] <= wr.hash;
			pair_mem[wr.addr[AW-1:0]] <= {wr.node, wr.evt};
		end
		if (rd_en) begin
			hraw_q <= hash_mem[rd_addr[AW-1:0]];
			pair_q <= pair_mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rd_en) begin
			vld_q <= valid_q[rd_addr[AW-1:0]];
		end
	end

	assign hash_rd = vld_q ? hraw_q : 8'd0;
	assign node_rd = pair_q[31:16];
	assign evt_rd  = pair_q[15:0];
endmodule

// ===== hdl/het_var_ram.sv =====
// Event variable byte memory, one port, registered read.
// No dependencies.
module het_var_ram #(
	parameter int DEPTH = 1024
) (
	input  logic        clk,
	input  logic        we,
	input  logic        re,
	input  logic [15:0] addr,
	input  logic [7:0]  wdata,
	output logic [7:0]  rdata
);
	localparam int DW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr[DW-1:0]] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr[DW-1:0]];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/hashed_event_table.sv =====
// Hashed event table: every request makes one pass over the hash and pair
// memories, one slot read per cycle, across the effective slot count n (min
// of slots_in_use and MAX_SLOTS), which yields count, find, free slot and the
// collision check. A new request is taken while the previous result still
// waits on the output register.
// Depends on het_pkg, het_hash, het_store, het_var_ram and assert_macros.svh.
`include "assert_macros.svh"
module hashed_event_table #(
	parameter int MAX_SLOTS    = 64,
	parameter int MAX_VARS     = 16,
	parameter int HASH_MODULUS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  command,
	input  logic [15:0] node_number,
	input  logic [15:0] event_number,
	input  logic [5:0]  slot_index,
	input  logic [4:0]  var_number,
	input  logic [7:0]  var_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  found_slot,
	output logic [7:0]  hash_out,
	output logic [6:0]  event_count,
	output logic [7:0]  var_out,
	output logic        collision
);
	typedef enum logic [2:0] {S_IDLE, S_WRITE, S_VAR, S_INIT, S_SCAN, S_FIN} state_t;

	state_t           state_q;
	logic [6:0]       slots_q;
	logic [4:0]       vars_q;
	het_pkg::cmd_t    cmd_q;
	logic [15:0]      nn_q, en_q;
	logic [7:0]       slot_q;
	logic [4:0]       vn_q;
	logic [7:0]       vd_q;
	logic [7:0]       n_q;
	logic             slot_ok_q, var_ok_q;
	logic [7:0]       rd_q;
	logic             s1_v;
	logic [7:0]       idx_s1;
	logic [7:0]       cnt_q, match_q, free_q, hcap_q;
	logic             mhit_q, fhit_q, scoll_q, coll_q;
	logic [255:0]     seen_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [6:0]       found_q, count_out_q;
	logic [7:0]       hash_out_q, var_out_q;
	logic             coll_out_q;

	logic [7:0]       n_eff;
	logic [6:0]       v_eff;
	logic [7:0]       new_hash, calc_hash, hash_rd;
	logic [15:0]      node_rd, evt_rd;
	logic [15:0]      var_addr;
	logic [7:0]       var_rd;
	logic             rd_en, in_acc, wr_slot_cmd, cfg_ok;
	het_pkg::het_wr_t wr;
	logic [1:0]       st_new;
	logic [6:0]       fnd_new;

	assign n_eff = (8'(slots_q) > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : 8'(slots_q);
	assign v_eff = (7'(vars_q) > 7'(MAX_VARS)) ? 7'(MAX_VARS) : 7'(vars_q);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign wr_slot_cmd = (cmd_q == het_pkg::CMD_WRITE) || (cmd_q == het_pkg::CMD_CLEAR);
	assign cfg_ok = slot_ok_q && var_ok_q;

	het_hash #(.HASH_MODULUS(HASH_MODULUS)) u_hash (
		.node(nn_q), .evt(en_q), .hash(calc_hash)
	);

	always_comb begin
		if (cmd_q == het_pkg::CMD_CLEAR) begin
			new_hash = 8'd0;
		end else if (nn_q == het_pkg::EMPTY_ID && en_q == het_pkg::EMPTY_ID) begin
			new_hash = 8'd0;
		end else begin
			new_hash = calc_hash;
		end
		wr.we      = (state_q == S_WRITE) && wr_slot_cmd;
		wr.clr_all = (state_q == S_WRITE) && (cmd_q == het_pkg::CMD_CLR_ALL);
		wr.addr    = slot_q;
		wr.hash    = new_hash;
		wr.node    = (cmd_q == het_pkg::CMD_CLEAR) ? het_pkg::EMPTY_ID : nn_q;
		wr.evt     = (cmd_q == het_pkg::CMD_CLEAR) ? het_pkg::EMPTY_ID : en_q;
	end

	assign rd_en = (state_q == S_SCAN) && (rd_q != n_q);

	het_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
		.clk(clk), .arst_n(arst_n), .wr(wr), .rd_en(rd_en), .rd_addr(rd_q),
		.hash_rd(hash_rd), .node_rd(node_rd), .evt_rd(evt_rd)
	);

	assign var_addr = 16'(16'(slot_q) * 16'(MAX_VARS)) + 16'(vn_q) - 16'd1;

	het_var_ram #(.DEPTH(MAX_SLOTS * MAX_VARS)) u_vars (
		.clk(clk),
		.we((state_q == S_VAR) && (cmd_q == het_pkg::CMD_WR_VAR)),
		.re((state_q == S_VAR) && (cmd_q == het_pkg::CMD_RD_VAR)),
		.addr(var_addr), .wdata(vd_q), .rdata(var_rd)
	);

	always_comb begin
		st_new = het_pkg::STAT_OK;
		fnd_new = 7'd0;
		case (cmd_q)
			het_pkg::CMD_FIND: begin
				st_new = mhit_q ? het_pkg::STAT_OK : het_pkg::STAT_MISS;
				fnd_new = mhit_q ? match_q[6:0] : n_q[6:0];
			end
			het_pkg::CMD_FREE: begin
				st_new = fhit_q ? het_pkg::STAT_OK : het_pkg::STAT_MISS;
				fnd_new = fhit_q ? free_q[6:0] : n_q[6:0];
			end
			het_pkg::CMD_WRITE, het_pkg::CMD_CLEAR, het_pkg::CMD_RD_HASH: begin
				st_new = slot_ok_q ? het_pkg::STAT_OK : het_pkg::STAT_RANGE;
				fnd_new = slot_q[6:0];
			end
			het_pkg::CMD_RD_VAR, het_pkg::CMD_WR_VAR: begin
				st_new = cfg_ok ? het_pkg::STAT_OK : het_pkg::STAT_RANGE;
				fnd_new = slot_q[6:0];
			end
			het_pkg::CMD_CLR_ALL, het_pkg::CMD_COUNT: begin
				st_new = het_pkg::STAT_OK;
			end
			default: begin
				st_new = het_pkg::STAT_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 7'd64;
			vars_q  <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				het_pkg::CFG_SLOTS: slots_q <= cfg_data;
				het_pkg::CFG_VARS:  vars_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q     <= het_pkg::cmd_t'(command);
			nn_q      <= node_number;
			en_q      <= event_number;
			slot_q    <= 8'(slot_index);
			vn_q      <= var_number;
			vd_q      <= var_data;
			n_q       <= n_eff;
			slot_ok_q <= 8'(slot_index) < n_eff;
			var_ok_q  <= (var_number != 5'd0) && (7'(var_number) <= v_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_q        <= '0;
			s1_v        <= 1'b0;
			idx_s1      <= '0;
			cnt_q       <= '0;
			match_q     <= '0;
			free_q      <= '0;
			hcap_q      <= '0;
			mhit_q      <= 1'b0;
			fhit_q      <= 1'b0;
			scoll_q     <= 1'b0;
			coll_q      <= 1'b0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			found_q     <= '0;
			count_out_q <= '0;
			hash_out_q  <= '0;
			var_out_q   <= '0;
			coll_out_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if ((command == het_pkg::CMD_WRITE || command == het_pkg::CMD_CLEAR)
						    && (8'(slot_index) < n_eff)) begin
							state_q <= S_WRITE;
						end else if (command == het_pkg::CMD_CLR_ALL) begin
							state_q <= S_WRITE;
						end else if ((command == het_pkg::CMD_RD_VAR
						    || command == het_pkg::CMD_WR_VAR)
						    && (8'(slot_index) < n_eff) && (var_number != 5'd0)
						    && (7'(var_number) <= v_eff)) begin
							state_q <= S_VAR;
						end else begin
							state_q <= S_INIT;
						end
					end
				end
				S_WRITE: begin
					if (cmd_q == het_pkg::CMD_CLR_ALL) begin
						coll_q <= 1'b0;
					end
					state_q <= S_INIT;
				end
				S_VAR: begin
					state_q <= S_INIT;
				end
				S_INIT: begin
					rd_q    <= '0;
					s1_v    <= 1'b0;
					cnt_q   <= '0;
					hcap_q  <= '0;
					mhit_q  <= 1'b0;
					fhit_q  <= 1'b0;
					scoll_q <= 1'b0;
					seen_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					s1_v   <= rd_en;
					idx_s1 <= rd_q;
					if (rd_en) begin
						rd_q <= rd_q + 8'd1;
					end
					if (s1_v) begin
						if (hash_rd != 8'd0) begin
							cnt_q <= cnt_q + 8'd1;
							if (seen_q[hash_rd]) begin
								scoll_q <= 1'b1;
							end
							seen_q[hash_rd] <= 1'b1;
							if (!mhit_q && node_rd == nn_q && evt_rd == en_q) begin
								mhit_q  <= 1'b1;
								match_q <= idx_s1;
							end
						end else if (!fhit_q) begin
							fhit_q <= 1'b1;
							free_q <= idx_s1;
						end
						if (idx_s1 == slot_q) begin
							hcap_q <= hash_rd;
						end
					end
					if (!rd_en && !s1_v) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= st_new;
						found_q     <= fnd_new;
						count_out_q <= cnt_q[6:0];
						hash_out_q  <= (slot_ok_q && (wr_slot_cmd
						                || cmd_q == het_pkg::CMD_RD_HASH)) ? hcap_q : 8'd0;
						var_out_q   <= (cfg_ok && cmd_q == het_pkg::CMD_RD_VAR) ? var_rd : 8'd0;
						if (wr_slot_cmd && slot_ok_q) begin
							coll_q     <= scoll_q;
							coll_out_q <= scoll_q;
						end else begin
							coll_out_q <= coll_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_slot  = found_q;
	assign hash_out    = hash_out_q;
	assign event_count = count_out_q;
	assign var_out     = var_out_q;
	assign collision   = coll_out_q;

	`HET_ASSERT_NEXT(a_busy_after_accept, in_acc, state_q != S_IDLE)
	`HET_ASSERT_NOW(a_count_bound, state_q == S_FIN, cnt_q <= n_q)
	`HET_ASSERT_NOW(a_scan_idle, state_q == S_IDLE, !s1_v)
endmodule

// ===== tb/hashed_event_table_tb.sv =====
// Self-checking testbench for hashed_event_table: directed and random requests
// through a queue-fed driver, checked against an in-bench table predictor.
// Depends on het_pkg and the hashed_event_table RTL.
`timescale 1ns / 1ps
module hashed_event_table_tb;

	localparam int NSLOT = 64;
	localparam int NVAR  = 16;
	localparam int HMOD  = 128;

	typedef struct {
		logic [3:0]  cmd;
		logic [15:0] nn;
		logic [15:0] en;
		logic [5:0]  slot;
		logic [4:0]  vn;
		logic [7:0]  vd;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [6:0] found;
		logic [7:0] hash;
		logic [6:0] count;
		logic [7:0] var_byte;
		logic       coll;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [6:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [3:0] command = 0;
	logic [15:0] node_number = 0;
	logic [15:0] event_number = 0;
	logic [5:0] slot_index = 0;
	logic [4:0] var_number = 0;
	logic [7:0] var_data = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [6:0] found_slot;
	logic [7:0] hash_out;
	logic [6:0] event_count;
	logic [7:0] var_out;
	logic collision;

	hashed_event_table u_dut (.*);

	always #5 clk = ~clk;

	// table image
	logic [15:0] tbl_node [NSLOT];
	logic [15:0] tbl_event [NSLOT];
	logic [7:0]  tbl_hash [NSLOT];
	logic [7:0]  tbl_vars [NSLOT*NVAR];
	logic        tbl_coll;
	int          reg_slots = 64;
	int          reg_vars = 16;
	bit          var_written [NSLOT*NVAR];

	request_t pending_requests [$];
	answer_t  expected_answers [$];
	int send_idle = 0, recv_idle = 0;
	int mismatches = 0, answers_checked = 0;
	int hold_requests = 0, holds_served = 0, hold_left = 0;
	int cmd_seen [16];

	function automatic int eff_slots();
		return reg_slots > NSLOT ? NSLOT : reg_slots;
	endfunction

	function automatic int eff_vars();
		return reg_vars > NVAR ? NVAR : reg_vars;
	endfunction

	function automatic logic [7:0] fold(logic [15:0] x);
		return x[7:0] ^ x[15:8];
	endfunction

	function automatic logic [7:0] pair_code(logic [15:0] nn, logic [15:0] en);
		int h;
		h = (7 * int'(fold(en)) + int'(fold(nn))) & 255;
		h = h % HMOD;
		return h == 0 ? 8'd255 : h[7:0];
	endfunction

	function automatic int used_slots();
		int c;
		c = 0;
		for (int i = 0; i < eff_slots(); i++)
			if (tbl_hash[i] != 0) c++;
		return c;
	endfunction

	function automatic void store_pair(int s, logic [15:0] nn, logic [15:0] en);
		int n;
		tbl_node[s] = nn;
		tbl_event[s] = en;
		tbl_hash[s] = (nn == het_pkg::EMPTY_ID && en == het_pkg::EMPTY_ID) ? 8'd0 :
			pair_code(nn, en);
		n = eff_slots();
		tbl_coll = 0;
		for (int i = 0; i < n; i++)
			if (tbl_hash[i] != 0)
				for (int j = i + 1; j < n; j++)
					if (tbl_hash[j] == tbl_hash[i]) tbl_coll = 1;
	endfunction

	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int n;
		bit slot_ok, var_ok;
		n = eff_slots();
		slot_ok = int'(r.slot) < n;
		var_ok = r.vn >= 1 && int'(r.vn) <= eff_vars();
		a = '{default: 0};
		case (r.cmd)
			het_pkg::CMD_FIND, het_pkg::CMD_FREE: begin
				a.found = 7'(n);
				for (int i = 0; i < n; i++)
					if ((r.cmd == het_pkg::CMD_FIND && tbl_hash[i] != 0 && tbl_node[i] == r.nn &&
					     tbl_event[i] == r.en) ||
					    (r.cmd == het_pkg::CMD_FREE && tbl_hash[i] == 0)) begin
						a.found = 7'(i);
						break;
					end
				a.status = (int'(a.found) == n) ? het_pkg::STAT_MISS : het_pkg::STAT_OK;
			end
			het_pkg::CMD_WRITE, het_pkg::CMD_CLEAR, het_pkg::CMD_RD_HASH: begin
				a.found = 7'(r.slot);
				if (!slot_ok) a.status = het_pkg::STAT_RANGE;
				else begin
					if (r.cmd == het_pkg::CMD_WRITE)
						store_pair(int'(r.slot), r.nn, r.en);
					else if (r.cmd == het_pkg::CMD_CLEAR)
						store_pair(int'(r.slot), het_pkg::EMPTY_ID, het_pkg::EMPTY_ID);
					a.hash = tbl_hash[r.slot];
				end
			end
			het_pkg::CMD_CLR_ALL: begin
				for (int i = 0; i < NSLOT; i++) begin
					tbl_node[i] = het_pkg::EMPTY_ID;
					tbl_event[i] = het_pkg::EMPTY_ID;
					tbl_hash[i] = 0;
				end
				tbl_coll = 0;
			end
			het_pkg::CMD_COUNT: ;
			het_pkg::CMD_RD_VAR, het_pkg::CMD_WR_VAR: begin
				a.found = 7'(r.slot);
				if (!slot_ok || !var_ok) a.status = het_pkg::STAT_RANGE;
				else if (r.cmd == het_pkg::CMD_RD_VAR)
					a.var_byte = tbl_vars[int'(r.slot)*NVAR + int'(r.vn) - 1];
				else tbl_vars[int'(r.slot)*NVAR + int'(r.vn) - 1] = r.vd;
			end
			default: a.status = het_pkg::STAT_RANGE;
		endcase
		a.count = 7'(used_slots());
		a.coll = tbl_coll;
		return a;
	endfunction

	// driver
	always @(posedge clk) begin
		request_t r;
		bit busy;
		busy = in_valid;
		if (in_valid && in_ready) begin
			r = '{command, node_number, event_number, slot_index, var_number, var_data};
			expected_answers.push_back(apply_request(r));
			cmd_seen[command]++;
			busy = 0;
		end
		if (!busy) begin
			if (arst_n && pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
				r = pending_requests.pop_front();
				command <= r.cmd;
				node_number <= r.nn;
				event_number <= r.en;
				slot_index <= r.slot;
				var_number <= r.vn;
				var_data <= r.vd;
				in_valid <= 1;
			end else
				in_valid <= 0;
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		answer_t e;
		if (out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected answer at %0t", $realtime);
			end else begin
				e = expected_answers.pop_front();
				answers_checked++;
				if (status !== e.status || found_slot !== e.found || hash_out !== e.hash ||
				    event_count !== e.count || var_out !== e.var_byte || collision !== e.coll) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp st=%0d slot=%0d h=%0d cnt=%0d v=%0d c=%0d got st=%0d slot=%0d h=%0d cnt=%0d v=%0d c=%0d",
							$realtime, e.status, e.found, e.hash, e.count, e.var_byte, e.coll,
							status, found_slot, hash_out, event_count, var_out, collision);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (hold_requests != holds_served) begin
			holds_served <= hold_requests;
			hold_left <= 600;
			out_ready <= 0;
		end else
			out_ready <= arst_n && $urandom_range(99) >= recv_idle;
	end

	task automatic wait_idle();
		wait (pending_requests.size() == 0 && expected_answers.size() == 0 && !in_valid);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 7'(value);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == het_pkg::CFG_SLOTS) reg_slots = value;
		else reg_vars = value;
	endtask

	function automatic void add(logic [3:0] c, logic [15:0] nn, logic [15:0] en,
			logic [5:0] s, logic [4:0] vn, logic [7:0] vd);
		if (c == het_pkg::CMD_WR_VAR && int'(s) < eff_slots() && vn >= 1 &&
		    int'(vn) <= eff_vars())
			var_written[int'(s)*NVAR + int'(vn) - 1] = 1;
		pending_requests.push_back('{c, nn, en, s, vn, vd});
	endfunction

	function automatic void add_random(int cnt);
		logic [15:0] pool_n [8], pool_e [8];
		logic [3:0] c;
		logic [15:0] nn, en;
		logic [5:0] s;
		logic [4:0] vn;
		int k, lim;
		for (int i = 0; i < 8; i++) begin
			pool_n[i] = 16'($urandom);
			pool_e[i] = 16'($urandom);
		end
		lim = eff_slots() > 0 ? eff_slots() - 1 : 0;
		for (int i = 0; i < cnt; i++) begin
			k = $urandom_range(99);
			nn = 16'($urandom);
			en = 16'($urandom);
			if ($urandom_range(3) != 0) begin
				k = $urandom_range(7);
				nn = pool_n[k];
				en = pool_e[k];
				k = $urandom_range(99);
			end
			s = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(lim));
			vn = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(16, 1));
			if (k < 25) c = het_pkg::CMD_WRITE;
			else if (k < 45) c = het_pkg::CMD_FIND;
			else if (k < 52) c = het_pkg::CMD_FREE;
			else if (k < 60) c = het_pkg::CMD_CLEAR;
			else if (k < 61) c = het_pkg::CMD_CLR_ALL;
			else if (k < 65) c = het_pkg::CMD_COUNT;
			else if (k < 72) c = het_pkg::CMD_RD_HASH;
			else if (k < 82) c = het_pkg::CMD_WR_VAR;
			else if (k < 97) c = het_pkg::CMD_RD_VAR;
			else c = 4'($urandom_range(15, int'(het_pkg::CMD_WR_VAR) + 1));
			if (c == het_pkg::CMD_RD_VAR && int'(s) < eff_slots() && vn >= 1 &&
			    int'(vn) <= eff_vars() && !var_written[int'(s)*NVAR + int'(vn) - 1])
				c = het_pkg::CMD_WR_VAR;
			add(c, nn, en, s, vn, 8'($urandom));
		end
	endfunction

	initial begin
		int slot_cfg [6] = '{64, 1, 7, 100, 0, 64};
		int var_cfg [6]  = '{16, 1, 5, 31, 0, 16};
		for (int i = 0; i < NSLOT; i++) begin
			tbl_node[i] = 0;
			tbl_event[i] = 0;
			tbl_hash[i] = 0;
		end
		foreach (tbl_vars[i]) tbl_vars[i] = 0;
		tbl_coll = 0;
		send_idle = 11;
		recv_idle = 81;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		add(het_pkg::CMD_COUNT, 0, 0, 0, 0, 0);
		add(het_pkg::CMD_FIND, 0, 0, 0, 0, 0);
		add(het_pkg::CMD_FREE, 0, 0, 0, 0, 0);
		add(het_pkg::CMD_WRITE, 16'h0000, 16'h0000, 0, 0, 0);
		add(het_pkg::CMD_WRITE, 16'hFFFF, 16'h0000, 63, 0, 0);
		add(het_pkg::CMD_WRITE, 16'h1234, 16'hABCD, 1, 0, 0);
		add(het_pkg::CMD_WRITE, 16'h1234, 16'hABCD, 2, 0, 0);
		add(het_pkg::CMD_FIND, 16'h1234, 16'hABCD, 0, 0, 0);
		add(het_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF, 1, 0, 0);
		add(het_pkg::CMD_RD_HASH, 0, 0, 1, 0, 0);
		add(het_pkg::CMD_RD_HASH, 0, 0, 63, 0, 0);
		add(het_pkg::CMD_CLEAR, 0, 0, 2, 0, 0);
		add(het_pkg::CMD_FREE, 0, 0, 0, 0, 0);
		add(het_pkg::CMD_WR_VAR, 0, 0, 0, 1, 8'hFF);
		add(het_pkg::CMD_WR_VAR, 0, 0, 63, 16, 8'h00);
		add(het_pkg::CMD_RD_VAR, 0, 0, 0, 1, 0);
		add(het_pkg::CMD_RD_VAR, 0, 0, 63, 16, 0);
		add(het_pkg::CMD_RD_VAR, 0, 0, 5, 0, 0);
		add(het_pkg::CMD_WR_VAR, 0, 0, 5, 17, 8'h5A);
		add(het_pkg::CMD_WR_VAR, 0, 0, 5, 31, 8'hA5);
		add(4'd9, 0, 0, 0, 0, 0);
		add(4'd15, 16'hFFFF, 16'hFFFF, 63, 31, 8'hFF);
		add(het_pkg::CMD_CLR_ALL, 0, 0, 0, 0, 0);
		add(het_pkg::CMD_FIND, 16'hFFFF, 16'hFFFF, 0, 0, 0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle = 81;
				recv_idle = 11;
			end else if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_reg(het_pkg::CFG_SLOTS, slot_cfg[p]);
			write_reg(het_pkg::CFG_VARS, var_cfg[p]);
			// write and read back slot 63 in each phase, out of range where fewer slots are set
			add(het_pkg::CMD_WRITE, 16'($urandom), 16'($urandom), 63, 0, 0);
			add(het_pkg::CMD_RD_HASH, 0, 0, 63, 0, 0);
			if (p == 5) hold_requests++;
			add_random(318);
			wait_idle();
		end

		$display("checked %0d answers over 7 register settings; writes %0d, finds %0d, var reads %0d",
			answers_checked, cmd_seen[het_pkg::CMD_WRITE], cmd_seen[het_pkg::CMD_FIND],
			cmd_seen[het_pkg::CMD_RD_VAR]);
		if (mismatches == 0)
			$display("simulation ok");
		else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

endmodule
